FILE: src/button_gesture_classifier_macros.svh
// ---------------------------------------------------------------------------
// button gesture classifier assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define BGC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BGC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/bgc_pkg.sv
// ---------------------------------------------------------------------------
// bgc_pkg
// types, codes and reset values of the button gesture classifier
// ---------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int CFG_WIDTH       = 16;
	localparam int APB_DATA_WIDTH  = 32;
	localparam int APB_ADDR_WIDTH  = 4;

	typedef logic [1:0]           gesture_t;
	typedef logic [1:0]           reg_idx_t;
	typedef logic [CFG_WIDTH-1:0] cfg_t;

	localparam gesture_t EV_NONE   = 2'd0;
	localparam gesture_t EV_SHORT  = 2'd1;
	localparam gesture_t EV_DOUBLE = 2'd2;
	localparam gesture_t EV_LONG   = 2'd3;

	localparam reg_idx_t REG_LONG     = 2'd0;
	localparam reg_idx_t REG_DEBOUNCE = 2'd1;
	localparam reg_idx_t REG_GAP      = 2'd2;

	localparam cfg_t LONG_RST     = 16'd1000;
	localparam cfg_t DEBOUNCE_RST = 16'd50;
	localparam cfg_t GAP_RST      = 16'd300;

endpackage

`default_nettype wire

FILE: src/button_gesture_classifier.sv
// a result is registered at its tick transfer; the skid entry takes it while an untaken result is shown
// throughput: one tick per cycle while the skid entry is empty; press and gap counters update in one pass
// a two-entry output stage (result register plus skid) keeps input open
// while one result waits
// reset: async active low; idle, counters zero, nothing pending, thresholds
// back to 1000 / 50 / 300 ticks
// ---------------------------------------------------------------------------
// button_gesture_classifier
// classifies press / release ticks into short, double and long presses
// ---------------------------------------------------------------------------
`default_nettype none
`include "button_gesture_classifier_macros.svh"

module button_gesture_classifier #(
	parameter int COUNT_WIDTH = bgc_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [bgc_pkg::APB_ADDR_WIDTH-1:0]  paddr,
	input  wire logic [bgc_pkg::APB_DATA_WIDTH-1:0]  pwdata,
	output logic      [bgc_pkg::APB_DATA_WIDTH-1:0]  prdata,
	output logic                                     pready,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                button_held,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output bgc_pkg::gesture_t                        gesture
);
	import bgc_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
	localparam logic PH_IDLE    = 1'b0;
	localparam logic PH_PRESSED = 1'b1;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == {COUNT_WIDTH{1'b1}}) ? v : v + cnt_t'(1);
	endfunction

	cfg_t long_q, debounce_q, gap_thr_q;
	logic phase_q, pending_q;
	cnt_t hold_q, gap_q;
	logic out_valid_q, skid_valid_q;
	gesture_t out_gesture_q, skid_gesture_q;

	logic     phase_d, pending_d;
	cnt_t     hold_d, gap_d, gap_inc;
	gesture_t ev;
	logic     in_xfer, out_xfer, cfg_wr;
	reg_idx_t cfg_idx;

	assign pready   = 1'b1;
	assign cfg_idx  = paddr[3:2];
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_ready = !skid_valid_q;
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign gesture   = out_gesture_q;

	always_comb begin
		unique case (cfg_idx)
			REG_LONG:     prdata = APB_DATA_WIDTH'(long_q);
			REG_DEBOUNCE: prdata = APB_DATA_WIDTH'(debounce_q);
			REG_GAP:      prdata = APB_DATA_WIDTH'(gap_thr_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q     <= LONG_RST;
			debounce_q <= DEBOUNCE_RST;
			gap_thr_q  <= GAP_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_LONG:     long_q     <= pwdata[CFG_WIDTH-1:0];
				REG_DEBOUNCE: debounce_q <= pwdata[CFG_WIDTH-1:0];
				REG_GAP:      gap_thr_q  <= pwdata[CFG_WIDTH-1:0];
				default:      ;
			endcase
		end
	end

	// one tick of the classifier
	always_comb begin
		gap_inc   = pending_q ? sat_inc(gap_q) : gap_q;
		phase_d   = phase_q;
		pending_d = pending_q;
		hold_d    = hold_q;
		gap_d     = gap_inc;
		ev        = EV_NONE;
		if (button_held) begin
			phase_d = PH_PRESSED;
			hold_d  = (phase_q == PH_IDLE) ? cnt_t'(1) : sat_inc(hold_q);
		end else if (phase_q == PH_PRESSED) begin
			phase_d = PH_IDLE;
			hold_d  = '0;
			if (CMP_W'(hold_q) >= CMP_W'(long_q)) begin
				ev        = EV_LONG;
				pending_d = 1'b0;
				gap_d     = '0;
			end else if (CMP_W'(hold_q) < CMP_W'(debounce_q)) begin
				gap_d = gap_inc;
			end else if (!pending_q) begin
				pending_d = 1'b1;
				gap_d     = '0;
			end else if (CMP_W'(gap_inc) <= CMP_W'(gap_thr_q)) begin
				ev        = EV_DOUBLE;
				pending_d = 1'b0;
				gap_d     = '0;
			end else begin
				gap_d = '0;
			end
		end else if (pending_q && (CMP_W'(gap_inc) > CMP_W'(gap_thr_q))) begin
			ev        = EV_SHORT;
			pending_d = 1'b0;
			gap_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pending_q <= 1'b0;
			hold_q    <= '0;
			gap_q     <= '0;
		end else if (in_xfer) begin
			phase_q   <= phase_d;
			pending_q <= pending_d;
			hold_q    <= hold_d;
			gap_q     <= gap_d;
		end
	end

	// result register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_xfer) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_xfer) begin
			if (out_valid_q && !out_xfer) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_xfer) begin
				out_gesture_q <= skid_gesture_q;
			end
		end else if (in_xfer) begin
			if (out_valid_q && !out_xfer) begin
				skid_gesture_q <= ev;
			end else begin
				out_gesture_q <= ev;
			end
		end
	end

	`BGC_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q,
		"skid entry valid without result register")
	`BGC_ASSERT_IMP(a_gap_idle_clear, !pending_q, gap_q == '0,
		"gap count nonzero with nothing pending")
	`BGC_ASSERT_IMP(a_hold_idle_clear, phase_q == PH_IDLE, hold_q == '0,
		"hold count nonzero while idle")
	`BGC_ASSERT_NXT(a_held_presses, in_xfer && button_held, phase_q == PH_PRESSED,
		"held tick did not leave the block pressed")

endmodule

`default_nettype wire

FILE: bench/gesture_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gesture_checker
// follows threshold writes and tick transfers, works out the gesture each tick
// should give and compares it with every result transfer, in order
// ---------------------------------------------------------------------------
module gesture_checker
	import bgc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic                      pready,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [APB_DATA_WIDTH-1:0] pwdata,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      button_held,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  gesture_t                  gesture,
	output int                        pending_results,
	output int                        fail_count
);

	typedef logic [COUNT_WIDTH-1:0] count_t;

	cfg_t     long_thr;
	cfg_t     bounce_thr;
	cfg_t     gap_thr;
	logic     btn_down;
	logic     waiting;
	count_t   press_len;
	count_t   gap_len;
	gesture_t want;
	gesture_t gesture_q[$];

	function automatic count_t bump(input count_t v);
		return (v == '1) ? v : v + count_t'(1);
	endfunction

	function automatic gesture_t classify_tick(input logic held);
		gesture_t ev;
		ev = EV_NONE;
		if (waiting)
			gap_len = bump(gap_len);
		if (held) begin
			if (!btn_down) begin
				btn_down = 1'b1;
				press_len = count_t'(1);
			end else begin
				press_len = bump(press_len);
			end
		end else if (btn_down) begin
			btn_down = 1'b0;
			if (press_len >= long_thr) begin
				ev = EV_LONG;
				waiting = 1'b0;
				gap_len = '0;
			end else if (press_len < bounce_thr) begin
				// bounce, pending press and gap kept
			end else if (!waiting) begin
				waiting = 1'b1;
				gap_len = '0;
			end else if (gap_len <= gap_thr) begin
				ev = EV_DOUBLE;
				waiting = 1'b0;
				gap_len = '0;
			end else begin
				gap_len = '0;
			end
			press_len = '0;
		end else if (waiting && gap_len > gap_thr) begin
			ev = EV_SHORT;
			waiting = 1'b0;
			gap_len = '0;
		end
		return ev;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_thr = LONG_RST;
			bounce_thr = DEBOUNCE_RST;
			gap_thr = GAP_RST;
			btn_down = 1'b0;
			waiting = 1'b0;
			press_len = '0;
			gap_len = '0;
			gesture_q.delete();
			pending_results = 0;
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (gesture_q.size() == 0) begin
					$error("gesture: unexpected result transfer, actual %0d", gesture);
					fail_count++;
				end else begin
					want = gesture_q.pop_front();
					if (gesture !== want) begin
						$error("gesture mismatch: expected %0d, actual %0d", want, gesture);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				gesture_q.push_back(classify_tick(button_held));
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_LONG:     long_thr = pwdata[CFG_WIDTH-1:0];
					REG_DEBOUNCE: bounce_thr = pwdata[CFG_WIDTH-1:0];
					REG_GAP:      gap_thr = pwdata[CFG_WIDTH-1:0];
					default:      ;
				endcase
			end
			pending_results = gesture_q.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// drives press and release tick sequences through the gesture classifier
// under several threshold settings and handshake pressure; gesture_checker
// judges every result and this module gives the verdict
// ---------------------------------------------------------------------------
module tb_top;
	import bgc_pkg::*;

	localparam int       CYCLE_LIMIT = 1000000;
	localparam reg_idx_t REG_UNUSED  = 2'd3;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [APB_ADDR_WIDTH-1:0] paddr = '0;
	logic [APB_DATA_WIDTH-1:0] pwdata = '0;
	logic [APB_DATA_WIDTH-1:0] prdata;
	logic                      pready;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      button_held = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	gesture_t                  gesture;

	int pending_results;
	int fail_count;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int ticks_sent = 0;
	int cycle_count = 0;
	int long_ticks = LONG_RST;
	int bounce_ticks = DEBOUNCE_RST;
	int gap_ticks = GAP_RST;

	button_gesture_classifier DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.button_held(button_held),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.gesture    (gesture)
	);

	gesture_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.button_held    (button_held),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.gesture        (gesture),
		.pending_results(pending_results),
		.fail_count     (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_tick(input logic lvl);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		button_held <= lvl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ticks_sent++;
	endtask

	task automatic hold(input logic lvl, input int n);
		repeat (n)
			send_tick(lvl);
	endtask

	// stop sending until every result is back, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_results != 0);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [15:0] value);
		logic [15:0] junk;
		junk = 16'($urandom);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {junk, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_thresholds(input int lng, input int deb, input int gap);
		drain();
		reg_write(REG_LONG, lng[15:0]);
		reg_write(REG_DEBOUNCE, deb[15:0]);
		reg_write(REG_GAP, gap[15:0]);
		long_ticks = lng;
		bounce_ticks = deb;
		gap_ticks = gap;
	endtask

	// lengths near the edges of a range or anywhere in it, lower edge only for wide ranges
	function automatic int pick_near(input int lo, input int hi);
		int sel;
		if (hi <= lo)
			return lo;
		if (hi - lo > 40)
			return $urandom_range(lo + 3, lo);
		sel = $urandom_range(2);
		if (sel == 0)
			return $urandom_range((hi < lo + 2) ? hi : lo + 2, lo);
		else if (sel == 1)
			return $urandom_range(hi, (hi - 2 > lo) ? hi - 2 : lo);
		return $urandom_range(hi, lo);
	endfunction

	task automatic play_gestures(input int n_ticks);
		int target;
		int kind;
		int len;
		int up;
		int bounce_hi;
		int valid_lo;
		int long_lo;
		target = ticks_sent + n_ticks;
		while (ticks_sent < target) begin
			kind = $urandom_range(99);
			bounce_hi = ((bounce_ticks < long_ticks) ? bounce_ticks : long_ticks) - 1;
			valid_lo = (bounce_ticks > 1) ? bounce_ticks : 1;
			long_lo = (long_ticks > 1) ? long_ticks : 1;
			if (kind < 15) begin
				hold(1'($urandom_range(1)), $urandom_range(6, 1));
			end else begin
				if (kind < 40 && bounce_hi >= 1)
					len = pick_near(1, bounce_hi);
				else if (kind < 80 && long_ticks - 1 >= valid_lo)
					len = pick_near(valid_lo, long_ticks - 1);
				else
					len = pick_near(long_lo, long_lo + 3);
				hold(1'b1, len);
				if ($urandom_range(1))
					up = pick_near(1, (gap_ticks > 1) ? gap_ticks : 1);
				else
					up = pick_near(gap_ticks + 1, gap_ticks + 4);
				hold(1'b0, up);
			end
		end
	endtask

	initial begin
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: one double press, one long press
		hold(1'b1, 60);
		hold(1'b0, 1);
		hold(1'b1, 60);
		hold(1'b0, 1);
		hold(1'b1, 1000);
		hold(1'b0, 2);

		// directed sequences on small thresholds
		set_thresholds(4, 2, 3);
		reg_write(REG_UNUSED, 16'hFFFF);
		hold(1'b1, 1);
		hold(1'b0, 1);
		hold(1'b1, 2);
		hold(1'b0, 1);
		hold(1'b1, 2);
		hold(1'b0, 1);
		hold(1'b1, 5);
		hold(1'b0, 1);
		hold(1'b1, 3);
		hold(1'b0, 5);
		// gap runs out while the second press is held
		hold(1'b1, 2);
		hold(1'b0, 1);
		hold(1'b1, 3);
		hold(1'b0, 5);
		// gap runs out across a bounce
		hold(1'b1, 2);
		hold(1'b0, 2);
		hold(1'b1, 1);
		hold(1'b0, 2);

		set_thresholds(8, 3, 6);
		play_gestures(150);

		src_idle_pct = 54;
		set_thresholds(5, 0, 4);
		play_gestures(150);

		src_idle_pct = 0;
		sink_stall_pct = 54;
		set_thresholds(12, 4, 10);
		play_gestures(75);
		drain();
		play_gestures(75);

		src_idle_pct = 18;
		sink_stall_pct = 18;
		set_thresholds(0, 1, 3);
		play_gestures(150);

		src_idle_pct = 0;
		sink_stall_pct = 54;
		set_thresholds(6, 2, 0);
		play_gestures(100);

		src_idle_pct = 54;
		sink_stall_pct = 0;
		set_thresholds(3, 65535, 2);
		play_gestures(100);

		drain();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
